// ===== design/tcphpcv_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP header parse and checksum verify package
// Shared types, constants and small arithmetic helpers for the parser.
// ----------------------------------------------------------------------------
package tcphpcv_pkg;

    // Number of leading segment bytes that are captured for the header fields.
    localparam int CAP_LEN   = 20;
    localparam int CAP_IDX_W = $clog2(CAP_LEN);

    // Position of the first checksum byte inside the segment.
    localparam int CKSUM_POS = 16;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Width of the raw pseudo header sum of four address halves and the protocol.
    localparam int PSUM_W = 19;

    // Well-known ports and their service codes.
    localparam logic [15:0] PORT_FTP    = 16'd21;
    localparam logic [15:0] PORT_TELNET = 16'd23;
    localparam logic [15:0] PORT_SMTP   = 16'd25;
    localparam logic [15:0] PORT_DNS    = 16'd53;
    localparam logic [15:0] PORT_HTTP   = 16'd80;
    localparam logic [15:0] PORT_POP3   = 16'd110;

    localparam logic [2:0] SVC_NONE   = 3'd0;
    localparam logic [2:0] SVC_FTP    = 3'd1;
    localparam logic [2:0] SVC_TELNET = 3'd2;
    localparam logic [2:0] SVC_SMTP   = 3'd3;
    localparam logic [2:0] SVC_DNS    = 3'd4;
    localparam logic [2:0] SVC_HTTP   = 3'd5;
    localparam logic [2:0] SVC_POP3   = 3'd6;

    // Input request types.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    typedef enum logic [1:0] {
        CHECK_OK,
        CHECK_BAD,
        CHECK_LEN_ERR
    } check_status_t;

    // Classification made by the front part.
    typedef enum logic [1:0] {
        KIND_START,
        KIND_LEN_ERR,
        KIND_DATA
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [15:0]         seg_len;
        logic [PSUM_W-1:0]   psum;
        logic [7:0]          data;
    } queue_entry_t;

    // One ones' complement addition with end-around carry.
    function automatic logic [15:0] add_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [2:0] service_code(input logic [15:0] port);
        logic [2:0] code;
        case (port)
            PORT_FTP:    code = SVC_FTP;
            PORT_TELNET: code = SVC_TELNET;
            PORT_SMTP:   code = SVC_SMTP;
            PORT_DNS:    code = SVC_DNS;
            PORT_HTTP:   code = SVC_HTTP;
            PORT_POP3:   code = SVC_POP3;
            default:     code = SVC_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/tcphpcv_front.sv =====
// ----------------------------------------------------------------------------
// TCP parser front part
// Accepts input transfers, classifies them and prepares the pseudo header
// length and partial sum for the back part.
// ----------------------------------------------------------------------------
module tcphpcv_front
(
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [31:0]                src_ip,
    input  logic [31:0]                dst_ip,
    input  logic [7:0]                 ip_protocol,
    input  logic [15:0]                ip_total_len,
    input  logic [3:0]                 ip_header_words,
    input  logic [7:0]                 seg_byte,
    input  logic                       queue_full,
    output logic                       push,
    output tcphpcv_pkg::queue_entry_t  entry
);
    import tcphpcv_pkg::*;

    logic [5:0]  ip_hdr_bytes;
    logic        len_err;
    logic [15:0] seg_len;
    logic [PSUM_W-1:0] psum;

    assign ip_hdr_bytes = {ip_header_words, 2'b00};
    assign len_err      = ip_total_len < {10'd0, ip_hdr_bytes};
    assign seg_len      = ip_total_len - {10'd0, ip_hdr_bytes};

    // The segment length is added by the back part; this is the rest of the
    // pseudo header as a plain wide sum, folded later.
    assign psum = {3'd0, src_ip[31:16]} + {3'd0, src_ip[15:0]}
                + {3'd0, dst_ip[31:16]} + {3'd0, dst_ip[15:0]}
                + {11'd0, ip_protocol};

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        entry.data = seg_byte;
        if (req_type == REQ_DATA)
        begin
            entry.kind    = KIND_DATA;
            entry.seg_len = 16'd0;
            entry.psum    = '0;
        end
        else if (len_err)
        begin
            entry.kind    = KIND_LEN_ERR;
            entry.seg_len = 16'd0;
            entry.psum    = '0;
        end
        else
        begin
            entry.kind    = KIND_START;
            entry.seg_len = seg_len;
            entry.psum    = psum;
        end
    end

endmodule

// ===== design/tcphpcv_queue.sv =====
// ----------------------------------------------------------------------------
// TCP parser item queue
// Short first-in first-out queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module tcphpcv_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tcphpcv_pkg::queue_entry_t  push_entry,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output tcphpcv_pkg::queue_entry_t  head
);
    import tcphpcv_pkg::*;

    queue_entry_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic [QUEUE_CNT_W-1:0]  count_next;

    assign full       = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QUEUE_CNT_W'(1)))
        else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== design/tcphpcv_back.sv =====
// ----------------------------------------------------------------------------
// TCP parser back part
// Runs the checksum, captures the header bytes and registers the results.
// ----------------------------------------------------------------------------
module tcphpcv_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  tcphpcv_pkg::queue_entry_t  head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                source_port,
    output logic [15:0]                dest_port,
    output logic [2:0]                 src_service,
    output logic [2:0]                 dst_service,
    output logic [31:0]                seq_number,
    output logic [31:0]                ack_number,
    output logic [5:0]                 header_bytes,
    output logic [7:0]                 flag_bits,
    output logic [15:0]                window_size,
    output logic [15:0]                segment_length,
    output logic [15:0]                stored_checksum,
    output logic [1:0]                 check_status
);
    import tcphpcv_pkg::*;

    // Packet state.
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [15:0] seg_len_reg;
    logic [15:0] seg_len_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic        in_packet_reg;
    logic        in_packet_next;
    logic [7:0]  cap_reg  [CAP_LEN];
    logic [7:0]  cap_next [CAP_LEN];

    // Result registers.
    logic          out_valid_reg;
    logic [15:0]   source_port_reg;
    logic [15:0]   dest_port_reg;
    logic [2:0]    src_service_reg;
    logic [2:0]    dst_service_reg;
    logic [31:0]   seq_number_reg;
    logic [31:0]   ack_number_reg;
    logic [5:0]    header_bytes_reg;
    logic [7:0]    flag_bits_reg;
    logic [15:0]   window_size_reg;
    logic [15:0]   segment_length_reg;
    logic [15:0]   stored_reg;
    check_status_t status_reg;

    logic          emit;
    logic [15:0]   fin_sum;
    logic [15:0]   stored_next;
    logic [15:0]   source_port_next;
    logic [15:0]   dest_port_next;
    check_status_t status_next;
    logic [PSUM_W-1:0] pseudo_raw;
    logic [16:0]   pseudo_fold;
    logic [7:0]    sum_byte;
    logic [15:0]   addend;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Pseudo header: add the segment length and fold the wide sum twice.
    assign pseudo_raw  = head.psum + {3'd0, head.seg_len};
    assign pseudo_fold = {1'b0, pseudo_raw[15:0]} + {14'd0, pseudo_raw[PSUM_W-1:16]};

    // Checksum bytes count as zero in the running sum.
    assign sum_byte = ((pos_reg == 16'(CKSUM_POS)) || (pos_reg == 16'(CKSUM_POS + 1)))
                    ? 8'd0 : head.data;
    // An odd position completes a word; an even one is padded for the
    // final value in case it is the last byte.
    assign addend = pos_reg[0] ? {hold_reg, sum_byte} : {sum_byte, 8'd0};

    always_comb
    begin
        pos_next       = pos_reg;
        seg_len_next   = seg_len_reg;
        sum_next       = sum_reg;
        hold_next      = hold_reg;
        in_packet_next = in_packet_reg;
        cap_next       = cap_reg;
        emit           = 1'b0;
        fin_sum        = sum_reg;
        if (pop)
        begin
            case (head.kind)
                KIND_LEN_ERR:
                begin
                    pos_next       = 16'd0;
                    seg_len_next   = 16'd0;
                    sum_next       = 16'd0;
                    hold_next      = 8'd0;
                    in_packet_next = 1'b0;
                    for (int i = 0; i < CAP_LEN; i++)
                    begin
                        cap_next[i] = 8'd0;
                    end
                    emit = 1'b1;
                end
                KIND_START:
                begin
                    pos_next       = 16'd0;
                    seg_len_next   = head.seg_len;
                    sum_next       = pseudo_fold[15:0] + {15'd0, pseudo_fold[16]};
                    hold_next      = 8'd0;
                    in_packet_next = head.seg_len != 16'd0;
                    for (int i = 0; i < CAP_LEN; i++)
                    begin
                        cap_next[i] = 8'd0;
                    end
                    fin_sum = sum_next;
                    emit    = head.seg_len == 16'd0;
                end
                KIND_DATA:
                begin
                    if (in_packet_reg)
                    begin
                        if (pos_reg < 16'(CAP_LEN))
                        begin
                            cap_next[pos_reg[CAP_IDX_W-1:0]] = head.data;
                        end
                        fin_sum   = add_fold(sum_reg, addend);
                        sum_next  = pos_reg[0] ? fin_sum : sum_reg;
                        hold_next = pos_reg[0] ? hold_reg : sum_byte;
                        pos_next  = pos_reg + 16'd1;
                        if (pos_next >= seg_len_reg)
                        begin
                            in_packet_next = 1'b0;
                            emit           = 1'b1;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign stored_next      = {cap_next[CKSUM_POS], cap_next[CKSUM_POS + 1]};
    assign source_port_next = {cap_next[0], cap_next[1]};
    assign dest_port_next   = {cap_next[2], cap_next[3]};

    always_comb
    begin
        if (head.kind == KIND_LEN_ERR)
        begin
            status_next = CHECK_LEN_ERR;
        end
        else if (~fin_sum == stored_next)
        begin
            status_next = CHECK_OK;
        end
        else
        begin
            status_next = CHECK_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 16'd0;
            seg_len_reg   <= 16'd0;
            sum_reg       <= 16'd0;
            hold_reg      <= 8'd0;
            in_packet_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CAP_LEN; i++)
            begin
                cap_reg[i] <= 8'd0;
            end
        end
        else
        begin
            pos_reg       <= pos_next;
            seg_len_reg   <= seg_len_next;
            sum_reg       <= sum_next;
            hold_reg      <= hold_next;
            in_packet_reg <= in_packet_next;
            cap_reg       <= cap_next;
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            source_port_reg    <= source_port_next;
            dest_port_reg      <= dest_port_next;
            src_service_reg    <= service_code(source_port_next);
            dst_service_reg    <= service_code(dest_port_next);
            seq_number_reg     <= {cap_next[4], cap_next[5], cap_next[6], cap_next[7]};
            ack_number_reg     <= {cap_next[8], cap_next[9], cap_next[10], cap_next[11]};
            header_bytes_reg   <= {cap_next[12][7:4], 2'b00};
            flag_bits_reg      <= cap_next[13];
            window_size_reg    <= {cap_next[14], cap_next[15]};
            segment_length_reg <= seg_len_next;
            stored_reg         <= stored_next;
            status_reg         <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign source_port     = source_port_reg;
    assign dest_port       = dest_port_reg;
    assign src_service     = src_service_reg;
    assign dst_service     = dst_service_reg;
    assign seq_number      = seq_number_reg;
    assign ack_number      = ack_number_reg;
    assign header_bytes    = header_bytes_reg;
    assign flag_bits       = flag_bits_reg;
    assign window_size     = window_size_reg;
    assign segment_length  = segment_length_reg;
    assign stored_checksum = stored_reg;
    assign check_status    = status_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("result appeared without a popped item");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> (pos_reg < seg_len_reg))
        else $error("open packet has already reached its length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == CHECK_LEN_ERR))
            |-> ((segment_length_reg == 16'd0) && (stored_reg == 16'd0)))
        else $error("length error result carries nonzero fields");
`endif

endmodule

// ===== design/tcp_header_parse_checksum_verify_core.sv =====
// ----------------------------------------------------------------------------
// TCP header parse and checksum verify core
// Parses a TCP segment byte by byte and verifies its checksum against the
// IP pseudo header.
// ----------------------------------------------------------------------------
// A packet starts with a start transfer (req_type 0) that carries the IP
// source and destination addresses, protocol, total length and header length,
// followed by one transfer per TCP segment byte (req_type 1) in wire order.
// The core takes one input transfer every clock cycle while the result side
// keeps up. The front part is combinational and writes each transfer into a
// two-entry queue at the edge that accepts it; the back part takes it from
// the queue when its result register is empty or being read; a single 16-bit
// ones' complement add with end-around carry per byte sets the rate. A result
// is registered when the back part takes the transfer that completes it: the
// last segment byte, a start whose segment length is zero, or a start whose
// total length is shorter than the IP header (length error, status 2, all other
// fields zero). The checksum bytes count as zero in the sum, an odd last byte
// is padded with a zero low byte, and header bytes that a short segment never
// delivers read as zero. Segment bytes with no packet open are dropped, and a
// new start abandons an open packet. The input stalls only when the queue is
// full, which happens when the output side stalls; a waiting result does not
// block the input until the queue fills.
// ----------------------------------------------------------------------------
module tcp_header_parse_checksum_verify_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [7:0]  ip_protocol,
    input  logic [15:0] ip_total_len,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  seg_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [2:0]  src_service,
    output logic [2:0]  dst_service,
    output logic [31:0] seq_number,
    output logic [31:0] ack_number,
    output logic [5:0]  header_bytes,
    output logic [7:0]  flag_bits,
    output logic [15:0] window_size,
    output logic [15:0] segment_length,
    output logic [15:0] stored_checksum,
    output logic [1:0]  check_status
);
    import tcphpcv_pkg::*;

    // Front to queue.
    logic         push;
    queue_entry_t push_entry;
    logic         queue_full;

    // Queue to back.
    logic         pop;
    logic         head_valid;
    queue_entry_t head;

    // The front part classifies each transfer and precomputes the pseudo
    // header pieces, so the back part only folds and accumulates.
    tcphpcv_front u_front
    (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .src_ip          (src_ip),
        .dst_ip          (dst_ip),
        .ip_protocol     (ip_protocol),
        .ip_total_len    (ip_total_len),
        .ip_header_words (ip_header_words),
        .seg_byte        (seg_byte),
        .queue_full      (queue_full),
        .push            (push),
        .entry           (push_entry)
    );

    // The queue lets the front keep taking transfers while the back part
    // waits on a stalled result.
    tcphpcv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back part owns all packet state and the result register.
    tcphpcv_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .src_service     (src_service),
        .dst_service     (dst_service),
        .seq_number      (seq_number),
        .ack_number      (ack_number),
        .header_bytes    (header_bytes),
        .flag_bits       (flag_bits),
        .window_size     (window_size),
        .segment_length  (segment_length),
        .stored_checksum (stored_checksum),
        .check_status    (check_status)
    );

endmodule

// ===== tb/tcp_header_checker.sv =====
// ----------------------------------------------------------------------------
// TCP header parse and checksum verify checker
// Watches both channels of the parser, predicts the result of every segment
// from the accepted input transfers, and compares each result field by field.
// ----------------------------------------------------------------------------
module tcp_header_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [7:0]  ip_protocol,
    input  logic [15:0] ip_total_len,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  seg_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [2:0]  src_service,
    input  logic [2:0]  dst_service,
    input  logic [31:0] seq_number,
    input  logic [31:0] ack_number,
    input  logic [5:0]  header_bytes,
    input  logic [7:0]  flag_bits,
    input  logic [15:0] window_size,
    input  logic [15:0] segment_length,
    input  logic [15:0] stored_checksum,
    input  logic [1:0]  check_status,
    output int          fail_count,
    output int          due_count,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcphpcv_pkg::*;

    typedef struct packed {
        logic [15:0]   sport;
        logic [15:0]   dport;
        logic [2:0]    ssvc;
        logic [2:0]    dsvc;
        logic [31:0]   seq;
        logic [31:0]   ack;
        logic [5:0]    hbytes;
        logic [7:0]    flags;
        logic [15:0]   win;
        logic [15:0]   seglen;
        logic [15:0]   stored;
        check_status_t status;
    } tcp_summary_t;

    // Parser state as the predictor sees it.
    logic [15:0] run_pos;
    logic [15:0] seg_expect;
    logic [15:0] fold_sum;
    logic [7:0]  pair_hi;
    logic [7:0]  hdr_cap [CAP_LEN];
    logic        seg_open;

    tcp_summary_t summaries_due [$];
    tcp_summary_t want;
    int           mismatches = 0;
    int           results_n  = 0;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [2:0] port_service(input logic [15:0] p);
        if (p == PORT_FTP)    return SVC_FTP;
        if (p == PORT_TELNET) return SVC_TELNET;
        if (p == PORT_SMTP)   return SVC_SMTP;
        if (p == PORT_DNS)    return SVC_DNS;
        if (p == PORT_HTTP)   return SVC_HTTP;
        if (p == PORT_POP3)   return SVC_POP3;
        return SVC_NONE;
    endfunction

    // Builds the result of the segment that has just closed.
    function automatic tcp_summary_t summarize_segment();
        tcp_summary_t s;
        logic [15:0]  total;
        logic [15:0]  computed;
        total = fold_sum;
        if (run_pos[0])
            total = ones_add(total, {pair_hi, 8'h00});
        computed  = ~total;
        s.sport   = {hdr_cap[0], hdr_cap[1]};
        s.dport   = {hdr_cap[2], hdr_cap[3]};
        s.ssvc    = port_service(s.sport);
        s.dsvc    = port_service(s.dport);
        s.seq     = {hdr_cap[4], hdr_cap[5], hdr_cap[6], hdr_cap[7]};
        s.ack     = {hdr_cap[8], hdr_cap[9], hdr_cap[10], hdr_cap[11]};
        s.hbytes  = {hdr_cap[12][7:4], 2'b00};
        s.flags   = hdr_cap[13];
        s.win     = {hdr_cap[14], hdr_cap[15]};
        s.seglen  = seg_expect;
        s.stored  = {hdr_cap[16], hdr_cap[17]};
        s.status  = (computed == s.stored) ? CHECK_OK : CHECK_BAD;
        return s;
    endfunction

    task automatic trace_transfer();
        logic [15:0]  ip_hdr;
        logic [7:0]   v;
        tcp_summary_t s;
        int           k;
        if (req_type == REQ_START) begin
            ip_hdr = {10'd0, ip_header_words, 2'b00};
            for (k = 0; k < CAP_LEN; k++)
                hdr_cap[k] = 8'h00;
            run_pos  = 16'd0;
            pair_hi  = 8'h00;
            seg_open = 1'b0;
            fold_sum = 16'h0000;
            if (ip_total_len < ip_hdr) begin
                seg_expect = 16'd0;
                s = '0;
                s.status = CHECK_LEN_ERR;
                summaries_due.push_back(s);
            end
            else begin
                seg_expect = ip_total_len - ip_hdr;
                fold_sum = ones_add(fold_sum, src_ip[31:16]);
                fold_sum = ones_add(fold_sum, src_ip[15:0]);
                fold_sum = ones_add(fold_sum, dst_ip[31:16]);
                fold_sum = ones_add(fold_sum, dst_ip[15:0]);
                fold_sum = ones_add(fold_sum, {8'h00, ip_protocol});
                fold_sum = ones_add(fold_sum, seg_expect);
                if (seg_expect == 16'd0)
                    summaries_due.push_back(summarize_segment());
                else
                    seg_open = 1'b1;
            end
        end
        else if (seg_open) begin
            // The checksum field itself is summed as zero.
            v = (run_pos == CKSUM_POS || run_pos == CKSUM_POS + 1) ? 8'h00 : seg_byte;
            if (run_pos < CAP_LEN)
                hdr_cap[run_pos] = seg_byte;
            if (!run_pos[0])
                pair_hi = v;
            else
                fold_sum = ones_add(fold_sum, {pair_hi, v});
            run_pos = run_pos + 16'd1;
            if (run_pos >= seg_expect) begin
                seg_open = 1'b0;
                summaries_due.push_back(summarize_segment());
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_pos    = 16'd0;
            seg_expect = 16'd0;
            fold_sum   = 16'h0000;
            pair_hi    = 8'h00;
            seg_open   = 1'b0;
            for (int k = 0; k < CAP_LEN; k++)
                hdr_cap[k] = 8'h00;
            summaries_due.delete();
            fail_count   <= 0;
            due_count    <= 0;
            results_seen <= 0;
        end
        else begin
            // Results are compared before this edge's input is predicted, so a
            // result can never be matched against an expectation born with it.
            if (out_valid && !out_stall) begin
                results_n++;
                if (summaries_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with none expected, expected nothing, actual status %0d",
                             $time, check_status);
                end
                else begin
                    want = summaries_due.pop_front();
                    check_field("source_port", want.sport, source_port);
                    check_field("dest_port", want.dport, dest_port);
                    check_field("src_service", want.ssvc, src_service);
                    check_field("dst_service", want.dsvc, dst_service);
                    check_field("seq_number", want.seq, seq_number);
                    check_field("ack_number", want.ack, ack_number);
                    check_field("header_bytes", want.hbytes, header_bytes);
                    check_field("flag_bits", want.flags, flag_bits);
                    check_field("window_size", want.win, window_size);
                    check_field("segment_length", want.seglen, segment_length);
                    check_field("stored_checksum", want.stored, stored_checksum);
                    check_field("check_status", want.status, check_status);
                end
            end
            if (in_valid && !in_stall)
                trace_transfer();
            fail_count   <= mismatches;
            due_count    <= summaries_due.size();
            results_seen <= results_n;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// TCP header parse and checksum verify testbench
// Drives packet starts and segment bytes into the parser with random bursts
// and output stalls, and lets the checker compare every result it gives.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcphpcv_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_total_len;
    logic [3:0]  ip_header_words;
    logic [7:0]  seg_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [2:0]  src_service;
    logic [2:0]  dst_service;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [5:0]  header_bytes;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] segment_length;
    logic [15:0] stored_checksum;
    logic [1:0]  check_status;

    int fail_count;
    int due_count;
    int results_seen;

    // Stimulus bookkeeping. Only transfers that the parser acts on are counted
    // toward the length of the run; stray bytes are tallied on their own.
    int burst_left    = 0;
    int counted_items = 0;
    int packets       = 0;
    int abandoned     = 0;
    int strays        = 0;
    bit pkt_open      = 1'b0;

    logic [15:0] wk_ports [6] = '{PORT_FTP, PORT_TELNET, PORT_SMTP,
                                  PORT_DNS, PORT_HTTP, PORT_POP3};

    tcp_header_parse_checksum_verify_core dut (.*);

    tcp_header_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run. A correct run finishes in a small fraction of it.
    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offers one transfer and holds it until the parser takes it. The sender
    // works in bursts: while a burst lasts, the next transfer follows on the
    // very next cycle; at the end of a burst valid drops for a random gap.
    task automatic offer(input logic rt, input logic [31:0] sip, input logic [31:0] dip,
                         input logic [7:0] proto, input logic [15:0] total,
                         input logic [3:0] hwords, input logic [7:0] b);
        in_valid        <= 1'b1;
        req_type        <= rt;
        src_ip          <= sip;
        dst_ip          <= dip;
        ip_protocol     <= proto;
        ip_total_len    <= total;
        ip_header_words <= hwords;
        seg_byte        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Fields that a transfer type does not use still get random values, so
    // every input bit is exercised on both kinds of transfer.
    task automatic send_start(input logic [31:0] sip, input logic [31:0] dip,
                              input logic [7:0] proto, input logic [15:0] total,
                              input logic [3:0] hwords);
        offer(REQ_START, sip, dip, proto, total, hwords, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer(REQ_DATA, $urandom, $urandom, 8'($urandom), 16'($urandom), 4'($urandom), b);
    endtask

    // Sends a start followed by n_send of the seg_len segment bytes. When fewer
    // bytes are sent than the length announces, the packet stays open and the
    // next start abandons it. With fix_cks set, seg_len at least 18 and the whole
    // segment sent, the checksum field is filled in so the segment verifies as correct.
    task automatic send_packet(input int seg_len, input int n_send, input bit fix_cks);
        logic [7:0]  body [];
        logic [31:0] sip;
        logic [31:0] dip;
        logic [7:0]  proto;
        logic [3:0]  hwords;
        logic [31:0] acc;
        logic [15:0] cks;
        logic [7:0]  lo;
        int          k;
        body = new[n_send];
        for (k = 0; k < n_send; k++)
            body[k] = 8'($urandom);
        // Well-known ports show up often enough to hit every service code.
        if (n_send >= 4) begin
            if ($urandom_range(0, 1))
                {body[0], body[1]} = wk_ports[$urandom_range(0, 5)];
            if ($urandom_range(0, 1))
                {body[2], body[3]} = wk_ports[$urandom_range(0, 5)];
        end
        sip = $urandom;
        dip = $urandom;
        case ($urandom_range(0, 9))
            0:       sip = '0;
            1:       dip = '1;
            default: ;
        endcase
        proto  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd6;
        hwords = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        if (fix_cks && n_send == seg_len && seg_len >= 18) begin
            body[16] = 8'h00;
            body[17] = 8'h00;
            acc = sip[31:16] + sip[15:0] + dip[31:16] + dip[15:0] + proto + 32'(seg_len);
            for (k = 0; k < seg_len; k += 2) begin
                lo = (k + 1 < seg_len) ? body[k + 1] : 8'h00;
                acc += {body[k], lo};
            end
            while (acc[31:16] != 16'd0)
                acc = acc[15:0] + acc[31:16];
            cks = ~acc[15:0];
            body[16] = cks[15:8];
            body[17] = cks[7:0];
        end
        send_start(sip, dip, proto, 16'(hwords * 4 + seg_len), hwords);
        for (k = 0; k < n_send; k++)
            send_byte(body[k]);
        pkt_open = (n_send < seg_len);
        counted_items += 1 + n_send;
        packets++;
        if (pkt_open)
            abandoned++;
    endtask

    // Receiver: stalls in spans of random length, each with its own pattern
    // (no stall, light, heavy, or alternating). Once, after the run is under
    // way, it holds off for a long stretch so that results back up, the
    // internal queue fills and the parser has to stall its input.
    initial begin
        int mode;
        int span;
        int k;
        int cycles;
        bit held_off;
        cycles   = 0;
        held_off = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held_off && cycles > 500) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                cycles += 300;
            end
            else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 60);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 2) == 0);
                        2:       out_stall <= ($urandom_range(0, 4) != 0);
                        default: out_stall <= k[1];
                    endcase
                    @(posedge clk);
                    cycles++;
                end
            end
        end
    end

    // Main stimulus: reset, a short directed part, then random packets.
    initial begin
        int r;
        int len;
        int hw;
        in_valid        <= 1'b0;
        req_type        <= REQ_START;
        src_ip          <= '0;
        dst_ip          <= '0;
        ip_protocol     <= '0;
        ip_total_len    <= '0;
        ip_header_words <= '0;
        seg_byte        <= '0;
        rst_n           <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Length error with the largest IP header and a zero total length.
        send_start('0, '0, '0, 16'd0, 4'd15);
        counted_items++;
        // A byte with no packet open must be dropped without a result.
        send_byte(8'hFF);
        strays++;
        // Empty segment with all-ones addresses: the result comes from the start.
        send_start('1, '1, 8'hFF, 16'd60, 4'd15);
        counted_items++;
        // Short, odd-length segment: source port 21, the rest reads as zero.
        send_start($urandom, $urandom, 8'd6, 16'd23, 4'd5);
        send_byte(8'h00);
        send_byte(8'd21);
        send_byte(8'h00);
        counted_items += 4;
        // Maximum total length with no IP header, abandoned by the next start,
        // which carries a full header with a correct checksum.
        send_start($urandom, $urandom, 8'd6, 16'hFFFF, 4'd0);
        send_byte(8'h50);
        counted_items += 2;
        send_packet(18, 18, 1'b1);

        while (counted_items < 750) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // Segment of 18 to 32 bytes, mostly with a checksum that verifies.
                len = $urandom_range(18, 32);
                send_packet(len, len, $urandom_range(0, 3) != 0);
            end
            else if (r < 70) begin
                // Segment shorter than a TCP header.
                len = $urandom_range(1, 17);
                send_packet(len, len, 1'b0);
            end
            else if (r < 74) begin
                send_packet(0, 0, 1'b0);
            end
            else if (r < 79) begin
                hw = $urandom_range(1, 15);
                send_start($urandom, $urandom, 8'($urandom),
                           16'($urandom_range(0, hw * 4 - 1)), 4'(hw));
                counted_items++;
                pkt_open = 1'b0;
            end
            else if (r < 84) begin
                len = $urandom_range(33, 90);
                send_packet(len, len, $urandom_range(0, 1));
            end
            else if (r < 92) begin
                // Broken sequence: the packet is cut short and restarted.
                len = $urandom_range(2, 40);
                send_packet(len, $urandom_range(0, len - 1), 1'b0);
            end
            else if (r < 95) begin
                // Very long announced segment, abandoned after a few bytes.
                send_packet($urandom_range(1000, 65000), $urandom_range(0, 25), 1'b0);
            end
            else if (!pkt_open) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom));
                    strays++;
                end
            end
            else begin
                send_packet(0, 0, 1'b0);
            end
        end
        in_valid <= 1'b0;

        // Drain: the checker's count is registered, so let it update first.
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d counted transfers in %0d packets (%0d abandoned), %0d stray bytes.",
                 counted_items, packets, abandoned, strays);
        $display("Checked %0d results, including length errors, empty and short segments.",
                 results_seen);
        if (fail_count == 0 && due_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
